[rtl/zcfe_pkg.sv]
// ----------------------------------------------------------------------------
// zcfe_pkg
// Shared widths, register indexes, result codes and reset values of the
// zero-crossing frequency estimator.
// ----------------------------------------------------------------------------
package zcfe_pkg;

  localparam int MAX_PERIODS_DEF = 1024;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int POS_W  = 48;
  localparam int FREQ_W = 27;
  localparam int CNT_W  = 32;
  localparam int THR_W  = 15;
  localparam int MD_W   = 16;
  localparam int SR_W   = 20;

  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam int OUT_RAW_W  = POS_W + FREQ_W + CNT_W + 1;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE  = 2'd2;

  localparam logic KIND_CROSSING = 1'b0;
  localparam logic KIND_SUMMARY  = 1'b1;

  localparam logic [THR_W-1:0] THRESHOLD_RST    = 15'd0;
  localparam logic [MD_W-1:0]  MIN_DISTANCE_RST = 16'd10;
  localparam logic [SR_W-1:0]  SAMPLE_RATE_RST  = 20'd44100;

endpackage

[rtl/zero_crossing_frequency_estimator.sv]
// ----------------------------------------------------------------------------
// zero_crossing_frequency_estimator
// A sample without a crossing or tlast leaves the input ready for the next one. A
// crossing takes a divider pass and a decision state before its result, if
// accepted, is offered. At block end with stored periods the upper median is
// found by a radix select of 48 scans over the period memory, then the divider
// runs once more (a single accepted crossing runs only the divider). Synchronous
// reset restores config defaults and clears only sample, crossing and period state.
// ----------------------------------------------------------------------------
module zero_crossing_frequency_estimator #(
  parameter int MAX_PERIODS = zcfe_pkg::MAX_PERIODS_DEF,
  parameter int FRAC_BITS   = zcfe_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = zcfe_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // position, frequency, crossing_count, periods_overflow
  output logic [zcfe_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // kind
  output logic m_axis_tuser,
  output logic m_axis_tlast,
  input  logic cfg_we,
  input  logic [zcfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [zcfe_pkg::CFG_W-1:0] cfg_data
);

  import zcfe_pkg::*;

  localparam int AW    = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1;
  localparam int PCW   = AW + 1;
  localparam int FDV_W = SAMPLE_BITS - 1 + FRAC_BITS;
  localparam int QDV_W = SR_W + FRAC_BITS + 8;
  localparam int DVW0  = (FDV_W > QDV_W) ? FDV_W : QDV_W;
  localparam int DVW   = (DVW0 > FREQ_W) ? DVW0 : FREQ_W;
  localparam int DCW   = $clog2(DVW + 1);
  localparam int BPW   = $clog2(POS_W);
  localparam int XW    = 34;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIVF  = 9'b000000010,
    S_CROSS = 9'b000000100,
    S_SENDC = 9'b000001000,
    S_EOB   = 9'b000010000,
    S_SEL   = 9'b000100000,
    S_DIVQ  = 9'b001000000,
    S_SENDS = 9'b010000000,
    S_DONEQ = 9'b100000000
  } state_t;

  state_t state;

  logic [THR_W-1:0] threshold;
  logic [MD_W-1:0]  min_distance;
  logic [SR_W-1:0]  sample_rate;

  logic [SAMPLE_BITS-1:0] previous_sample;
  logic                   have_previous;
  logic [CNT_W-1:0]       sample_index;
  logic                   have_crossing;
  logic [POS_W-1:0]       last_crossing_pos;
  logic [CNT_W-1:0]       accepted_count;
  logic [PCW-1:0]         period_count;
  logic                   overflow_flag;

  logic             eob;
  logic [CNT_W-1:0] cross_idx;

  logic [DVW-1:0]   dvd;
  logic [POS_W-1:0] dvs;
  logic [POS_W-1:0] rem;
  logic [DVW-1:0]   quo;
  logic [DCW-1:0]   dcnt;

  logic [BPW-1:0]   bitpos;
  logic [PCW-1:0]   scan;
  logic             rd_valid;
  logic [PCW-1:0]   cnt0;
  logic [PCW-1:0]   rank;
  logic [POS_W-1:0] prefix;

  logic [POS_W-1:0] mem [MAX_PERIODS];
  logic [POS_W-1:0] rd_data;
  logic             mem_we;
  logic [POS_W-1:0] mem_wdata;

  logic                 o_kind;
  logic [POS_W-1:0]     o_pos;
  logic [FREQ_W-1:0]    o_freq;
  logic [CNT_W-1:0]     o_cnt;
  logic                 o_ovf;
  logic                 o_last;

  logic in_fire;
  logic signed [XW-1:0] cur_w, prev_w, thr_w, diff_w;
  logic crossing;
  logic [SR_W-1:0] sr_eff;
  logic [MD_W-1:0] md_eff;
  logic [POS_W-1:0] pos, per, mdq, bitmask, hi_mask, med;
  logic accept;
  logic [POS_W:0] rem_sh, rem_sub;
  logic ge;
  logic [DVW-1:0] lim, fq;
  logic [PCW-1:0] cnt0_add;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_SENDC) || (state == S_SENDS);
  assign m_axis_tdata  = OUT_DATA_W'({o_ovf, o_cnt, o_freq, o_pos});
  assign m_axis_tuser  = o_kind;
  assign m_axis_tlast  = o_last;

  always_comb begin
    cur_w  = XW'($signed(s_axis_tdata[SAMPLE_BITS-1:0]));
    prev_w = XW'($signed(previous_sample));
    thr_w  = $signed({{(XW-THR_W){1'b0}}, threshold});
    diff_w = prev_w - cur_w;
    crossing = have_previous && (prev_w > thr_w) && (cur_w < -thr_w);

    sr_eff = (sample_rate == '0) ? SR_W'(1) : sample_rate;
    md_eff = (min_distance == '0) ? MD_W'(1) : min_distance;

    pos = POS_W'({cross_idx, {FRAC_BITS{1'b0}}}) + POS_W'(quo[FRAC_BITS-1:0]);
    per = pos - last_crossing_pos;
    mdq = POS_W'({md_eff, {FRAC_BITS{1'b0}}});
    accept = !have_crossing || ((pos >= last_crossing_pos) && (per >= mdq));

    rem_sh  = {rem, dvd[DVW-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    ge      = (rem_sh >= {1'b0, dvs});

    bitmask = POS_W'(1) << bitpos;
    hi_mask = ~((bitmask << 1) - POS_W'(1));
    cnt0_add = (rd_valid && (((rd_data ^ prefix) & hi_mask) == '0)
                && ((rd_data & bitmask) == '0)) ? PCW'(1) : PCW'(0);
    med = (rank < cnt0) ? prefix : (prefix | bitmask);

    lim = DVW'({sr_eff, 7'b0});
    fq  = (quo > lim) ? lim : quo;

    mem_we    = (state == S_CROSS) && accept && have_crossing && (per != '0)
                && (period_count < PCW'(MAX_PERIODS));
    mem_wdata = per;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[period_count[AW-1:0]] <= mem_wdata;
    end
    rd_data <= mem[scan[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      threshold         <= THRESHOLD_RST;
      min_distance      <= MIN_DISTANCE_RST;
      sample_rate       <= SAMPLE_RATE_RST;
      previous_sample   <= '0;
      have_previous     <= 1'b0;
      sample_index      <= '0;
      have_crossing     <= 1'b0;
      last_crossing_pos <= '0;
      accepted_count    <= '0;
      period_count      <= '0;
      overflow_flag     <= 1'b0;
      rd_valid          <= 1'b0;
      dcnt              <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THRESHOLD:    threshold    <= cfg_data[THR_W-1:0];
          REG_MIN_DISTANCE: min_distance <= cfg_data[MD_W-1:0];
          REG_SAMPLE_RATE:  sample_rate  <= cfg_data[SR_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            eob       <= s_axis_tlast;
            cross_idx <= (sample_index == '0) ? '0 : sample_index - CNT_W'(1);
            previous_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
            have_previous   <= 1'b1;
            if (sample_index != {CNT_W{1'b1}}) begin
              sample_index <= sample_index + CNT_W'(1);
            end
            if (crossing) begin
              dvd  <= DVW'({previous_sample[SAMPLE_BITS-2:0], {FRAC_BITS{1'b0}}});
              dvs  <= POS_W'(diff_w[SAMPLE_BITS-1:0]);
              rem  <= '0;
              dcnt <= DCW'(DVW);
              state <= S_DIVF;
            end else if (s_axis_tlast) begin
              state <= S_EOB;
            end
          end
        end

        S_DIVF, S_DIVQ: begin
          if (dcnt != '0) begin
            rem  <= ge ? rem_sub[POS_W-1:0] : rem_sh[POS_W-1:0];
            dvd  <= dvd << 1;
            quo  <= {quo[DVW-2:0], ge};
            dcnt <= dcnt - DCW'(1);
          end else begin
            state <= (state == S_DIVF) ? S_CROSS : S_DONEQ;
          end
        end

        S_CROSS: begin
          if (accept) begin
            if (have_crossing && (per != '0)) begin
              if (period_count < PCW'(MAX_PERIODS)) begin
                period_count <= period_count + PCW'(1);
              end else begin
                overflow_flag <= 1'b1;
              end
            end
            have_crossing     <= 1'b1;
            last_crossing_pos <= pos;
            if (accepted_count != {CNT_W{1'b1}}) begin
              accepted_count <= accepted_count + CNT_W'(1);
            end
            o_kind <= KIND_CROSSING;
            o_pos  <= pos;
            o_freq <= '0;
            o_cnt  <= '0;
            o_ovf  <= 1'b0;
            o_last <= !eob;
            state  <= S_SENDC;
          end else begin
            state <= eob ? S_EOB : S_IDLE;
          end
        end

        S_SENDC: begin
          if (m_axis_tready) begin
            state <= eob ? S_EOB : S_IDLE;
          end
        end

        S_EOB: begin
          if ((accepted_count >= CNT_W'(2)) && (period_count != '0)) begin
            bitpos   <= BPW'(POS_W - 1);
            scan     <= '0;
            rd_valid <= 1'b0;
            cnt0     <= '0;
            rank     <= period_count >> 1;
            prefix   <= '0;
            state    <= S_SEL;
          end else if (accepted_count == CNT_W'(1)) begin
            dvd  <= DVW'({sr_eff, 7'b0});
            dvs  <= POS_W'(sample_index);
            rem  <= '0;
            dcnt <= DCW'(DVW);
            state <= S_DIVQ;
          end else begin
            o_kind <= KIND_SUMMARY;
            o_pos  <= '0;
            o_freq <= '0;
            o_cnt  <= accepted_count;
            o_ovf  <= overflow_flag;
            o_last <= 1'b1;
            state  <= S_SENDS;
          end
        end

        S_SEL: begin
          if (scan < period_count) begin
            scan     <= scan + PCW'(1);
            rd_valid <= 1'b1;
            cnt0     <= cnt0 + cnt0_add;
          end else if (rd_valid) begin
            rd_valid <= 1'b0;
            cnt0     <= cnt0 + cnt0_add;
          end else begin
            prefix <= med;
            if (rank >= cnt0) begin
              rank <= rank - cnt0;
            end
            cnt0 <= '0;
            scan <= '0;
            if (bitpos == '0) begin
              dvd  <= DVW'({sr_eff, {(FRAC_BITS + 8){1'b0}}});
              dvs  <= med;
              rem  <= '0;
              dcnt <= DCW'(DVW);
              state <= S_DIVQ;
            end else begin
              bitpos <= bitpos - BPW'(1);
            end
          end
        end

        S_DONEQ: begin
          o_kind <= KIND_SUMMARY;
          o_pos  <= '0;
          o_freq <= fq[FREQ_W-1:0];
          o_cnt  <= accepted_count;
          o_ovf  <= overflow_flag;
          o_last <= 1'b1;
          state  <= S_SENDS;
        end

        S_SENDS: begin
          if (m_axis_tready) begin
            previous_sample   <= '0;
            have_previous     <= 1'b0;
            sample_index      <= '0;
            have_crossing     <= 1'b0;
            last_crossing_pos <= '0;
            accepted_count    <= '0;
            period_count      <= '0;
            overflow_flag     <= 1'b0;
            state             <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
